// ===== src/ssr_pkg.sv =====
`timescale 1ns / 1ps

package ssr_pkg;

    localparam int MAX_DIM_DEF     = 64;
    localparam int MAX_MATCHES_DEF = 64;

    localparam int ELEM_W  = 16;
    localparam int COORD_W = 6;
    localparam int DIM_W   = 7;
    localparam int CFG_AW  = 2;

    localparam logic [1:0] OP_LOAD_MAIN = 2'd0;
    localparam logic [1:0] OP_LOAD_PAT  = 2'd1;
    localparam logic [1:0] OP_SEARCH    = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_MAIN_ROWS = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MAIN_COLS = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_PAT_ROWS  = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_PAT_COLS  = 2'd3;

    localparam logic [DIM_W-1:0] RST_MAIN_ROWS = 7'd64;
    localparam logic [DIM_W-1:0] RST_MAIN_COLS = 7'd64;
    localparam logic [DIM_W-1:0] RST_PAT_ROWS  = 7'd1;
    localparam logic [DIM_W-1:0] RST_PAT_COLS  = 7'd1;

endpackage

// ===== src/submatrix_search_top.sv =====
`timescale 1ns / 1ps
// Load transfer: ready stays high, so loads are accepted back to back.
// Search transfer: a setup step, then per compared element a read of the main and pattern
// store read ports and a compare, an emit step per reported match after the first, and a
// final step for the final result; each emit and the final step wait while the output
// register is still full, and the block is not ready until the final result is queued.
// Reset (synchronous, active low) clears the sequencer and output valid, presets config dims.

module submatrix_search_top #(
    parameter int MAX_DIM     = ssr_pkg::MAX_DIM_DEF,
    parameter int MAX_MATCHES = ssr_pkg::MAX_MATCHES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ssr_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [ssr_pkg::DIM_W-1:0]  i_cfg_wdata,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // row[5:0], col[11:6], value[27:12], zero[31:28]
    input  logic [31:0]               i_s_tdata,
    // op[1:0]
    input  logic [1:0]                i_s_tuser,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // match_row[5:0], match_col[11:6], match_count[18:12], overflow[19], zero[23:20]
    output logic [23:0]               o_m_tdata,
    // found[0]
    output logic                      o_m_tuser,
    output logic                      o_m_tlast
);

    localparam int AW        = $clog2(MAX_DIM);
    localparam int RAM_AW    = 2 * AW;
    localparam int RAM_DEPTH = 1 << RAM_AW;
    localparam int DIM_LIM   = (MAX_DIM < 64) ? MAX_DIM : 64;
    localparam int CW        = ssr_pkg::COORD_W;
    localparam int DW        = ssr_pkg::DIM_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_READ  = 6'b000100,
        S_CMP   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_FINAL = 6'b100000
    } t_state;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        logic [DW-1:0] res;
        res = v;
        if (v == '0) begin
            res = DW'(1);
        end else if (v > DW'(DIM_LIM)) begin
            res = DW'(DIM_LIM);
        end
        return res;
    endfunction

    t_state r_state, n_state;
    logic [DW-1:0] r_cfg_mr, r_cfg_mc, r_cfg_pr, r_cfg_pc;
    logic [DW-1:0] r_mr, n_mr, r_mc, n_mc, r_pr, n_pr, r_pc, n_pc;
    logic [CW-1:0] r_rlim, n_rlim, r_clim, n_clim;
    logic [CW-1:0] r_r, n_r, r_c, n_c, r_p, n_p, r_q, n_q;
    logic          r_pend_valid, n_pend_valid;
    logic [CW-1:0] r_pend_row, n_pend_row, r_pend_col, n_pend_col;
    logic [DW-1:0] r_count, n_count;
    logic          r_more, n_more;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_out_row, n_out_row, r_out_col, n_out_col;
    logic [DW-1:0] r_out_count, n_out_count;
    logic          r_out_found, n_out_found, r_out_ovf, n_out_ovf, r_out_last, n_out_last;

    logic              s_acc, out_free, load_ok;
    logic [CW-1:0]     in_row, in_col;
    logic [15:0]       in_value;
    logic [RAM_AW-1:0] waddr, main_raddr, pat_raddr;
    logic [7:0]        row_ext, col_ext, sum_r, sum_c, p_ext, q_ext;
    logic [15:0]       main_rdata, pat_rdata;
    logic              elem_last, pos_last;
    logic [CW-1:0]     adv_r, adv_c;
    t_state            adv_state;

    assign in_row   = i_s_tdata[5:0];
    assign in_col   = i_s_tdata[11:6];
    assign in_value = i_s_tdata[27:12];
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    assign row_ext = {2'b00, in_row};
    assign col_ext = {2'b00, in_col};
    assign load_ok = ({1'b0, row_ext} < 9'(MAX_DIM)) && ({1'b0, col_ext} < 9'(MAX_DIM));
    assign waddr   = {row_ext[AW-1:0], col_ext[AW-1:0]};

    assign p_ext      = {2'b00, r_p};
    assign q_ext      = {2'b00, r_q};
    assign sum_r      = {2'b00, r_r} + p_ext;
    assign sum_c      = {2'b00, r_c} + q_ext;
    assign main_raddr = {sum_r[AW-1:0], sum_c[AW-1:0]};
    assign pat_raddr  = {p_ext[AW-1:0], q_ext[AW-1:0]};

    ssr_ram #(.WIDTH(ssr_pkg::ELEM_W), .DEPTH(RAM_DEPTH)) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc && (i_s_tuser == ssr_pkg::OP_LOAD_MAIN) && load_ok),
        .i_waddr (waddr),
        .i_wdata (in_value),
        .i_raddr (main_raddr),
        .o_rdata (main_rdata)
    );

    ssr_ram #(.WIDTH(ssr_pkg::ELEM_W), .DEPTH(RAM_DEPTH)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc && (i_s_tuser == ssr_pkg::OP_LOAD_PAT) && load_ok),
        .i_waddr (waddr),
        .i_wdata (in_value),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    assign elem_last = (({1'b0, r_p} + DW'(1)) == r_pr) && (({1'b0, r_q} + DW'(1)) == r_pc);
    assign pos_last  = (r_r == r_rlim) && (r_c == r_clim);

    always_comb begin
        adv_r     = r_r;
        adv_c     = r_c + CW'(1);
        adv_state = S_READ;
        if (r_c == r_clim) begin
            adv_c = '0;
            adv_r = r_r + CW'(1);
        end
        if (pos_last) begin
            adv_state = S_FINAL;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_mr         = r_mr;
        n_mc         = r_mc;
        n_pr         = r_pr;
        n_pc         = r_pc;
        n_rlim       = r_rlim;
        n_clim       = r_clim;
        n_r          = r_r;
        n_c          = r_c;
        n_p          = r_p;
        n_q          = r_q;
        n_pend_valid = r_pend_valid;
        n_pend_row   = r_pend_row;
        n_pend_col   = r_pend_col;
        n_count      = r_count;
        n_more       = r_more;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_count  = r_out_count;
        n_out_found  = r_out_found;
        n_out_ovf    = r_out_ovf;
        n_out_last   = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (s_acc && (i_s_tuser == ssr_pkg::OP_SEARCH)) begin
                    n_mr         = clamp_dim(r_cfg_mr);
                    n_mc         = clamp_dim(r_cfg_mc);
                    n_pr         = clamp_dim(r_cfg_pr);
                    n_pc         = clamp_dim(r_cfg_pc);
                    n_pend_valid = 1'b0;
                    n_count      = '0;
                    n_more       = 1'b0;
                    n_state      = S_START;
                end
            end
            S_START: begin
                n_rlim = CW'(r_mr - r_pr);
                n_clim = CW'(r_mc - r_pc);
                n_r    = '0;
                n_c    = '0;
                n_p    = '0;
                n_q    = '0;
                if ((r_pr <= r_mr) && (r_pc <= r_mc)) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (main_rdata != pat_rdata) begin
                    n_r     = adv_r;
                    n_c     = adv_c;
                    n_p     = '0;
                    n_q     = '0;
                    n_state = adv_state;
                end else if (!elem_last) begin
                    if (({1'b0, r_q} + DW'(1)) == r_pc) begin
                        n_q = '0;
                        n_p = r_p + CW'(1);
                    end else begin
                        n_q = r_q + CW'(1);
                    end
                    n_state = S_READ;
                end else if (r_count == DW'(MAX_MATCHES)) begin
                    n_more  = 1'b1;
                    n_state = S_FINAL;
                end else if (r_pend_valid) begin
                    n_state = S_EMIT;
                end else begin
                    n_pend_valid = 1'b1;
                    n_pend_row   = r_r;
                    n_pend_col   = r_c;
                    n_count      = r_count + DW'(1);
                    n_r          = adv_r;
                    n_c          = adv_c;
                    n_p          = '0;
                    n_q          = '0;
                    n_state      = adv_state;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_pend_row;
                    n_out_col   = r_pend_col;
                    n_out_count = r_count;
                    n_out_found = 1'b1;
                    n_out_ovf   = 1'b0;
                    n_out_last  = 1'b0;
                    n_pend_row  = r_r;
                    n_pend_col  = r_c;
                    n_count     = r_count + DW'(1);
                    n_r         = adv_r;
                    n_c         = adv_c;
                    n_p         = '0;
                    n_q         = '0;
                    n_state     = adv_state;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (r_pend_valid) begin
                        n_out_row   = r_pend_row;
                        n_out_col   = r_pend_col;
                        n_out_count = r_count;
                        n_out_found = 1'b1;
                        n_out_ovf   = r_more;
                    end else begin
                        n_out_row   = '0;
                        n_out_col   = '0;
                        n_out_count = '0;
                        n_out_found = 1'b0;
                        n_out_ovf   = 1'b0;
                    end
                    n_pend_valid = 1'b0;
                    n_count      = '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_mr     <= ssr_pkg::RST_MAIN_ROWS;
            r_cfg_mc     <= ssr_pkg::RST_MAIN_COLS;
            r_cfg_pr     <= ssr_pkg::RST_PAT_ROWS;
            r_cfg_pc     <= ssr_pkg::RST_PAT_COLS;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
            r_more       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_count      <= n_count;
            r_more       <= n_more;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ssr_pkg::CFG_MAIN_ROWS: r_cfg_mr <= i_cfg_wdata;
                    ssr_pkg::CFG_MAIN_COLS: r_cfg_mc <= i_cfg_wdata;
                    ssr_pkg::CFG_PAT_ROWS:  r_cfg_pr <= i_cfg_wdata;
                    ssr_pkg::CFG_PAT_COLS:  r_cfg_pc <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mr        <= n_mr;
        r_mc        <= n_mc;
        r_pr        <= n_pr;
        r_pc        <= n_pc;
        r_rlim      <= n_rlim;
        r_clim      <= n_clim;
        r_r         <= n_r;
        r_c         <= n_c;
        r_p         <= n_p;
        r_q         <= n_q;
        r_pend_row  <= n_pend_row;
        r_pend_col  <= n_pend_col;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_count <= n_out_count;
        r_out_found <= n_out_found;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_ovf, r_out_count, r_out_col, r_out_row};
    assign o_m_tuser  = r_out_found;
    assign o_m_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (i_s_tuser == ssr_pkg::OP_SEARCH)) |=> !o_s_tready)
        else $error("ready high right after a search transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DW'(MAX_MATCHES))
        else $error("match count beyond limit");

    a_nomatch_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast && (o_m_tdata[18:12] == '0)))
        else $error("no-match result malformed");

    a_ovf_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[19]) |-> (o_m_tlast && (o_m_tdata[18:12] == DW'(MAX_MATCHES))))
        else $error("overflow on a result other than the last full one");

    a_pend_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid == (r_count != '0)))
        else $error("pending match and count disagree");
`endif

endmodule

// ===== src/ssr_ram.sv =====
`timescale 1ns / 1ps

module ssr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
